// ===== hdl/assert_macros.svh =====
// assertion helpers used by the stream parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PCSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define PCSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/pcsp_pkg.sv =====
`default_nettype none

package pcsp_pkg;

	// kind of each result
	typedef enum logic [1:0] {
		KIND_FRAME     = 2'd0,
		KIND_PAYLOAD   = 2'd1,
		KIND_CHUNK_END = 2'd2
	} pcsp_kind_t;

	// parse status
	typedef enum logic [2:0] {
		ST_RUNNING   = 3'd0,
		ST_OK        = 3'd1,
		ST_BAD_SIG   = 3'd2,
		ST_TRUNCATED = 3'd3,
		ST_SHORT_HDR = 3'd4,
		ST_BAD_DIMS  = 3'd5
	} pcsp_status_t;

	// one result, as produced by the parser core
	typedef struct packed {
		pcsp_kind_t   kind;
		logic [7:0]   payload;
		logic [31:0]  ctype;
		logic [31:0]  clength;
		logic         finished;
		pcsp_status_t status;
		logic [31:0]  width;
		logic [31:0]  height;
	} pcsp_result_t;

endpackage

`default_nettype wire

// ===== hdl/pcsp_core.sv =====
`default_nettype none

module pcsp_core
	import pcsp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step_en,
	input  wire logic [7:0]   data_byte,
	input  wire logic         last_byte,
	output pcsp_result_t      result
);

	localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
	localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
	localparam logic [31:0] IHDR_MIN  = 32'd13;

	typedef enum logic [2:0] {
		PH_SIG  = 3'd0,
		PH_LEN  = 3'd1,
		PH_TYPE = 3'd2,
		PH_DATA = 3'd3,
		PH_CRC  = 3'd4,
		PH_DONE = 3'd5
	} phase_t;

	phase_t       phase_q, phase_n;
	logic [31:0]  count_q, count_n;
	logic [31:0]  length_q, length_n;
	logic [31:0]  type_q, type_n;
	logic [31:0]  width_q, width_n;
	logic [31:0]  height_q, height_n;
	pcsp_status_t status_q, status_n;
	pcsp_kind_t   kind;
	logic [7:0]   pay;
	logic [31:0]  count_inc;

	// png signature, one byte per position
	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0: b = 8'h89;
			3'd1: b = 8'h50;
			3'd2: b = 8'h4E;
			3'd3: b = 8'h47;
			3'd4: b = 8'h0D;
			3'd5: b = 8'h0A;
			3'd6: b = 8'h1A;
			default: b = 8'h0A;
		endcase
		return b;
	endfunction

	// both sizes nonzero and below 2^31
	function automatic pcsp_status_t dims_status(input logic [31:0] w, input logic [31:0] h);
		pcsp_status_t s;
		if (w != 32'd0 && h != 32'd0 && !w[31] && !h[31])
			s = ST_OK;
		else
			s = ST_BAD_DIMS;
		return s;
	endfunction

	assign count_inc = count_q + 32'd1;

	// next state for one byte
	always_comb begin
		phase_n  = phase_q;
		count_n  = count_q;
		length_n = length_q;
		type_n   = type_q;
		width_n  = width_q;
		height_n = height_q;
		status_n = status_q;
		kind     = KIND_FRAME;
		pay      = 8'd0;

		unique case (phase_q)
			PH_SIG: begin
				if (data_byte != sig_byte(count_q[2:0])) begin
					phase_n  = PH_DONE;
					status_n = ST_BAD_SIG;
				end else if (count_q[2:0] == 3'd7) begin
					phase_n  = PH_LEN;
					count_n  = 32'd0;
					length_n = 32'd0;
					type_n   = 32'd0;
				end else begin
					count_n = count_inc;
				end
			end
			PH_LEN: begin
				length_n = {length_q[23:0], data_byte};
				if (count_q[1:0] == 2'd3) begin
					phase_n = PH_TYPE;
					count_n = 32'd0;
				end else begin
					count_n = count_inc;
				end
			end
			PH_TYPE: begin
				type_n = {type_q[23:0], data_byte};
				if (count_q[1:0] == 2'd3) begin
					count_n = 32'd0;
					if (length_q == 32'd0) begin
						// zero-length chunk ends on its last type byte
						kind = KIND_CHUNK_END;
						if (type_n == TYPE_IHDR) begin
							phase_n  = PH_DONE;
							status_n = ST_SHORT_HDR;
						end else if (type_n == TYPE_IEND) begin
							phase_n  = PH_DONE;
							status_n = dims_status(width_q, height_q);
						end else begin
							phase_n = PH_CRC;
						end
					end else begin
						phase_n = PH_DATA;
					end
				end else begin
					count_n = count_inc;
				end
			end
			PH_DATA: begin
				kind = KIND_PAYLOAD;
				pay  = data_byte;
				// first eight bytes of a full ihdr carry width then height
				if (type_q == TYPE_IHDR && length_q >= IHDR_MIN && count_q[31:3] == 29'd0) begin
					if (!count_q[2])
						width_n = {width_q[23:0], data_byte};
					else
						height_n = {height_q[23:0], data_byte};
				end
				count_n = count_inc;
				if (count_inc == length_q) begin
					kind    = KIND_CHUNK_END;
					count_n = 32'd0;
					if (type_q == TYPE_IHDR && length_q < IHDR_MIN) begin
						phase_n  = PH_DONE;
						status_n = ST_SHORT_HDR;
					end else if (type_q == TYPE_IEND) begin
						phase_n  = PH_DONE;
						status_n = dims_status(width_n, height_n);
					end else begin
						phase_n = PH_CRC;
					end
				end
			end
			PH_CRC: begin
				if (count_q[1:0] == 2'd3) begin
					phase_n  = PH_LEN;
					count_n  = 32'd0;
					length_n = 32'd0;
					type_n   = 32'd0;
				end else begin
					count_n = count_inc;
				end
			end
			default: begin
			end
		endcase

		// end of file closes an open parse
		if (last_byte && phase_n != PH_DONE) begin
			if (phase_n == PH_SIG)
				status_n = ST_BAD_SIG;
			else if (phase_n == PH_DATA)
				status_n = ST_TRUNCATED;
			else
				status_n = dims_status(width_n, height_n);
			phase_n = PH_DONE;
		end
	end

	// result reflects state after this byte, before any rearm
	always_comb begin
		result.kind     = kind;
		result.payload  = pay;
		result.ctype    = type_n;
		result.clength  = length_n;
		result.finished = (phase_n == PH_DONE);
		result.status   = status_n;
		result.width    = width_n;
		result.height   = height_n;
	end

	// parser state, rearmed after the last byte of a file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIG;
			count_q  <= 32'd0;
			length_q <= 32'd0;
			type_q   <= 32'd0;
			width_q  <= 32'd0;
			height_q <= 32'd0;
			status_q <= ST_RUNNING;
		end else if (step_en) begin
			if (last_byte) begin
				phase_q  <= PH_SIG;
				count_q  <= 32'd0;
				length_q <= 32'd0;
				type_q   <= 32'd0;
				width_q  <= 32'd0;
				height_q <= 32'd0;
				status_q <= ST_RUNNING;
			end else begin
				phase_q  <= phase_n;
				count_q  <= count_n;
				length_q <= length_n;
				type_q   <= type_n;
				width_q  <= width_n;
				height_q <= height_n;
				status_q <= status_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/png_chunk_stream_parser.sv =====
// a byte accepted into the input register reaches the output via the core and the result register
// throughput: one byte per cycle while the result register drains, set by the parser state update
// a held result stalls the input only once the input register is also full
// reset: arst_n clears both stage valids and rearms the parser to the signature
// the parser also rearms on its own after each request flagged last_byte
`default_nettype none

module png_chunk_stream_parser
	import pcsp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       out_kind,
	output logic [7:0]       payload_byte,
	output logic [31:0]      chunk_type,
	output logic [31:0]      chunk_length,
	output logic             finished,
	output logic [2:0]       status,
	output logic [31:0]      canvas_width,
	output logic [31:0]      canvas_height
);

`include "assert_macros.svh"

	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         last_s1;
	logic         valid_s2;
	pcsp_result_t result_s2;
	pcsp_result_t core_result;
	logic         advance;

	// stage 1 moves on whenever the result register is free or drains
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	pcsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.result    (core_result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= core_result;
	end

	assign out_valid     = valid_s2;
	assign out_kind      = result_s2.kind;
	assign payload_byte  = result_s2.payload;
	assign chunk_type    = result_s2.ctype;
	assign chunk_length  = result_s2.clength;
	assign finished      = result_s2.finished;
	assign status        = result_s2.status;
	assign canvas_width  = result_s2.width;
	assign canvas_height = result_s2.height;

	// checks
	`PCSP_ASSERT_NXT(a_accept_fills_s1, clk, arst_n, in_valid && in_ready, valid_s1,
		"accepted request not held in stage 1")
	`PCSP_ASSERT_IMP(a_no_overrun, clk, arst_n, valid_s1 && valid_s2 && !out_ready, !in_ready,
		"input taken while both stages are full")
	`PCSP_ASSERT_IMP(a_finished_status, clk, arst_n, valid_s2 && finished,
		status != ST_RUNNING, "finished result with running status")
	`PCSP_ASSERT_IMP(a_payload_end, clk, arst_n,
		valid_s2 && finished && out_kind == KIND_PAYLOAD, status == ST_TRUNCATED,
		"parse ended on a plain data byte without truncation")

endmodule

`default_nettype wire
